// File: rtl/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg
// Types, constants and the multiply schedule shared by the closest-hit unit.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int unsigned DivSteps = 48;
    localparam logic [4:0]  MopLast  = 5'd23;
    localparam logic [4:0]  PtFirst  = 5'd24;
    localparam logic [4:0]  PtLast   = 5'd26;

    localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMin = 32'sh8000_0000;
    localparam logic signed [31:0] QOne = 32'sd65536;

    localparam logic [2:0] CFG_ORG_X = 3'd0;
    localparam logic [2:0] CFG_ORG_Y = 3'd1;
    localparam logic [2:0] CFG_ORG_Z = 3'd2;
    localparam logic [2:0] CFG_DIR_X = 3'd3;
    localparam logic [2:0] CFG_DIR_Y = 3'd4;
    localparam logic [2:0] CFG_DIR_Z = 3'd5;

    typedef enum logic [4:0] {
        OPD_E1X, OPD_E1Y, OPD_E1Z,
        OPD_E2X, OPD_E2Y, OPD_E2Z,
        OPD_SX,  OPD_SY,  OPD_SZ,
        OPD_DX,  OPD_DY,  OPD_DZ,
        OPD_HX,  OPD_HY,  OPD_HZ,
        OPD_QX,  OPD_QY,  OPD_QZ,
        OPD_BEST
    } t_opd;

    typedef enum logic [2:0] {
        ACC_NONE, ACC_CROSS_FIRST, ACC_CROSS_LAST,
        ACC_DOT_FIRST, ACC_DOT_MID, ACC_DOT_LAST, ACC_POINT
    } t_acc;

    typedef enum logic [3:0] {
        DST_NONE, DST_HX, DST_HY, DST_HZ, DST_QX, DST_QY, DST_QZ,
        DST_A, DST_NU, DST_NV, DST_NT, DST_PX, DST_PY, DST_PZ
    } t_dst;

    typedef enum logic [1:0] {
        DIV_U, DIV_V, DIV_T
    } t_dsel;

    typedef struct packed {
        t_opd a;
        t_opd b;
        t_acc acc;
        t_dst dst;
    } t_mop;

    typedef struct packed {
        logic  capture;
        t_mop  mop;
        logic  div_start;
        t_dsel div_sel;
        logic  upd;
        logic  count;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic a_zero;
        logic u_ok;
        logic v_ok;
        logic any_hit;
        logic last;
        logic div_busy;
        logic div_done;
    } t_sts;

    function automatic logic signed [31:0] sat66(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = QMax;
        end else if (x < -66'sd2147483648) begin
            r = QMin;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return sat66(66'(d));
    endfunction

    // Multiply schedule: h = d x e2, a = e1.h, s.h, q = s x e1, d.q, e2.q,
    // then the three hit-point products.
    function automatic t_mop mop_of(input logic [4:0] step);
        t_mop m;
        case (step)
            5'd0:  m = '{OPD_DY, OPD_E2Z, ACC_CROSS_FIRST, DST_NONE};
            5'd1:  m = '{OPD_DZ, OPD_E2Y, ACC_CROSS_LAST,  DST_HX};
            5'd2:  m = '{OPD_DZ, OPD_E2X, ACC_CROSS_FIRST, DST_NONE};
            5'd3:  m = '{OPD_DX, OPD_E2Z, ACC_CROSS_LAST,  DST_HY};
            5'd4:  m = '{OPD_DX, OPD_E2Y, ACC_CROSS_FIRST, DST_NONE};
            5'd5:  m = '{OPD_DY, OPD_E2X, ACC_CROSS_LAST,  DST_HZ};
            5'd6:  m = '{OPD_E1X, OPD_HX, ACC_DOT_FIRST,   DST_NONE};
            5'd7:  m = '{OPD_E1Y, OPD_HY, ACC_DOT_MID,     DST_NONE};
            5'd8:  m = '{OPD_E1Z, OPD_HZ, ACC_DOT_LAST,    DST_A};
            5'd9:  m = '{OPD_SX, OPD_HX, ACC_DOT_FIRST,    DST_NONE};
            5'd10: m = '{OPD_SY, OPD_HY, ACC_DOT_MID,      DST_NONE};
            5'd11: m = '{OPD_SZ, OPD_HZ, ACC_DOT_LAST,     DST_NU};
            5'd12: m = '{OPD_SY, OPD_E1Z, ACC_CROSS_FIRST, DST_NONE};
            5'd13: m = '{OPD_SZ, OPD_E1Y, ACC_CROSS_LAST,  DST_QX};
            5'd14: m = '{OPD_SZ, OPD_E1X, ACC_CROSS_FIRST, DST_NONE};
            5'd15: m = '{OPD_SX, OPD_E1Z, ACC_CROSS_LAST,  DST_QY};
            5'd16: m = '{OPD_SX, OPD_E1Y, ACC_CROSS_FIRST, DST_NONE};
            5'd17: m = '{OPD_SY, OPD_E1X, ACC_CROSS_LAST,  DST_QZ};
            5'd18: m = '{OPD_DX, OPD_QX, ACC_DOT_FIRST,    DST_NONE};
            5'd19: m = '{OPD_DY, OPD_QY, ACC_DOT_MID,      DST_NONE};
            5'd20: m = '{OPD_DZ, OPD_QZ, ACC_DOT_LAST,     DST_NV};
            5'd21: m = '{OPD_E2X, OPD_QX, ACC_DOT_FIRST,   DST_NONE};
            5'd22: m = '{OPD_E2Y, OPD_QY, ACC_DOT_MID,     DST_NONE};
            5'd23: m = '{OPD_E2Z, OPD_QZ, ACC_DOT_LAST,    DST_NT};
            5'd24: m = '{OPD_DX, OPD_BEST, ACC_POINT,      DST_PX};
            5'd25: m = '{OPD_DY, OPD_BEST, ACC_POINT,      DST_PY};
            5'd26: m = '{OPD_DZ, OPD_BEST, ACC_POINT,      DST_PZ};
            default: m = '{OPD_E1X, OPD_E1X, ACC_NONE,     DST_NONE};
        endcase
        return m;
    endfunction

endpackage

// File: rtl/ray_triangle_closest_hit_unit.sv
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_unit
// Moller-Trumbore closest-hit search over a stream of triangles, Q16.16.
// ----------------------------------------------------------------------------
// Write the ray origin and direction through the configuration channel, then
// send triangles one request at a time; the request flagged last_triangle
// produces one result with the nearest hit (first triangle wins on equal
// distance) and clears the hit record. One triangle is worked on at a time.
// A triangle runs the multiply schedule on the single shared 32x32 multiplier,
// then up to three 48-step radix-2 divisions by the determinant: it stops
// before the first when its determinant is zero, after the u division when u
// fails and after the v division when v fails. The last triangle adds the
// hit-point products when there was a hit. The result register lets the next
// triangle be taken while a result still waits to be collected.
module ray_triangle_closest_hit_unit #(
    parameter int unsigned MAX_TRIANGLES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_v0_x,
    input  logic signed [31:0] i_v0_y,
    input  logic signed [31:0] i_v0_z,
    input  logic signed [31:0] i_v1_x,
    input  logic signed [31:0] i_v1_y,
    input  logic signed [31:0] i_v1_z,
    input  logic signed [31:0] i_v2_x,
    input  logic signed [31:0] i_v2_y,
    input  logic signed [31:0] i_v2_z,
    input  logic               i_last_triangle,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit_found,
    output logic signed [31:0] o_hit_distance,
    output logic signed [31:0] o_bary_u,
    output logic signed [31:0] o_bary_v,
    output logic [15:0]        o_hit_index,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z
);

    rtc_pkg::t_cmd cmd;
    rtc_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    rtc_dp #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_v0_x          (i_v0_x),
        .i_v0_y          (i_v0_y),
        .i_v0_z          (i_v0_z),
        .i_v1_x          (i_v1_x),
        .i_v1_y          (i_v1_y),
        .i_v1_z          (i_v1_z),
        .i_v2_x          (i_v2_x),
        .i_v2_y          (i_v2_y),
        .i_v2_z          (i_v2_z),
        .i_last_triangle (i_last_triangle),
        .o_hit_found     (o_hit_found),
        .o_hit_distance  (o_hit_distance),
        .o_bary_u        (o_bary_u),
        .o_bary_v        (o_bary_v),
        .o_hit_index     (o_hit_index),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_point_z       (o_point_z)
    );

    rtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

endmodule

// File: rtl/rtc_div.sv
// ----------------------------------------------------------------------------
// rtc_div
// Radix-2 restoring divider: (num << 16) / den, truncated toward zero and
// saturated to signed 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_busy,
    output logic               o_done,
    output logic signed [31:0] o_quo
);

    logic [47:0]        r_dvd;
    logic [31:0]        r_dsr;
    logic [32:0]        r_rem;
    logic [47:0]        r_quo;
    logic [5:0]         r_cnt;
    logic               r_neg;
    logic               r_busy;
    logic               r_done;
    logic signed [31:0] r_res;

    logic [31:0]        num_mag;
    logic [31:0]        den_mag;
    logic [32:0]        rem_sh;
    logic [32:0]        rem_nx;
    logic               qbit;
    logic [47:0]        quo_nx;
    logic signed [31:0] res_nx;

    always_comb begin
        num_mag = i_num[31] ? 32'(-i_num) : 32'(i_num);
        den_mag = i_den[31] ? 32'(-i_den) : 32'(i_den);
        rem_sh  = {r_rem[31:0], r_dvd[47]};
        qbit    = (rem_sh >= {1'b0, r_dsr});
        rem_nx  = qbit ? (rem_sh - {1'b0, r_dsr}) : rem_sh;
        quo_nx  = {r_quo[46:0], qbit};
        if (r_neg) begin
            res_nx = (quo_nx > 48'h0000_8000_0000) ? rtc_pkg::QMin : -$signed(quo_nx[31:0]);
        end else begin
            res_nx = (quo_nx > 48'h0000_7FFF_FFFF) ? rtc_pkg::QMax : $signed(quo_nx[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(rtc_pkg::DivSteps);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {num_mag, 16'h0000};
            r_dsr <= den_mag;
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            r_dvd <= {r_dvd[46:0], 1'b0};
            r_rem <= rem_nx;
            r_quo <= quo_nx;
            if (r_cnt == 6'd1) begin
                r_res <= res_nx;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_res;

endmodule

// File: rtl/rtc_dp.sv
// ----------------------------------------------------------------------------
// rtc_dp
// Datapath: ray registers, edge vectors, one shared 32x32 multiplier with an
// accumulator, the divider, the nearest-hit record and the result register.
// ----------------------------------------------------------------------------
module rtc_dp #(
    parameter int unsigned MAX_TRIANGLES = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rtc_pkg::t_cmd      i_cmd,
    output rtc_pkg::t_sts      o_sts,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [31:0] i_v0_x,
    input  logic signed [31:0] i_v0_y,
    input  logic signed [31:0] i_v0_z,
    input  logic signed [31:0] i_v1_x,
    input  logic signed [31:0] i_v1_y,
    input  logic signed [31:0] i_v1_z,
    input  logic signed [31:0] i_v2_x,
    input  logic signed [31:0] i_v2_y,
    input  logic signed [31:0] i_v2_z,
    input  logic               i_last_triangle,
    output logic               o_hit_found,
    output logic signed [31:0] o_hit_distance,
    output logic signed [31:0] o_bary_u,
    output logic signed [31:0] o_bary_v,
    output logic [15:0]        o_hit_index,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z
);

    localparam logic [15:0] CntLast = 16'(MAX_TRIANGLES - 1);

    logic signed [31:0] r_org [3];
    logic signed [31:0] r_dir [3];
    logic signed [31:0] r_e1 [3];
    logic signed [31:0] r_e2 [3];
    logic signed [31:0] r_s [3];
    logic signed [31:0] r_h [3];
    logic signed [31:0] r_q [3];
    logic signed [31:0] r_p [3];
    logic signed [31:0] r_a, r_nu, r_nv, r_nt, r_u, r_v, r_t;
    logic signed [31:0] r_best_dist, r_best_u, r_best_v;
    logic [15:0]        r_best_idx;
    logic               r_any;
    logic [15:0]        r_cnt;
    logic               r_last;
    logic signed [63:0] r_prod;
    rtc_pkg::t_mop      r_mop1;
    logic signed [65:0] r_acc;
    rtc_pkg::t_dsel     r_dsel;

    logic               r_o_hit;
    logic signed [31:0] r_o_dist, r_o_u, r_o_v, r_o_px, r_o_py, r_o_pz;
    logic [15:0]        r_o_idx;

    logic signed [31:0] opd_a, opd_b;
    logic signed [47:0] prod_f;
    logic signed [65:0] n_acc;
    logic signed [31:0] org_k;
    logic signed [31:0] res;
    logic signed [31:0] div_num;
    logic               div_busy, div_done;
    logic signed [31:0] div_quo;
    logic signed [32:0] uv_sum;
    logic               t_ok;
    logic               better;

    function automatic logic signed [31:0] opd_val(input rtc_pkg::t_opd o);
        logic signed [31:0] r;
        case (o)
            rtc_pkg::OPD_E1X:  r = r_e1[0];
            rtc_pkg::OPD_E1Y:  r = r_e1[1];
            rtc_pkg::OPD_E1Z:  r = r_e1[2];
            rtc_pkg::OPD_E2X:  r = r_e2[0];
            rtc_pkg::OPD_E2Y:  r = r_e2[1];
            rtc_pkg::OPD_E2Z:  r = r_e2[2];
            rtc_pkg::OPD_SX:   r = r_s[0];
            rtc_pkg::OPD_SY:   r = r_s[1];
            rtc_pkg::OPD_SZ:   r = r_s[2];
            rtc_pkg::OPD_DX:   r = r_dir[0];
            rtc_pkg::OPD_DY:   r = r_dir[1];
            rtc_pkg::OPD_DZ:   r = r_dir[2];
            rtc_pkg::OPD_HX:   r = r_h[0];
            rtc_pkg::OPD_HY:   r = r_h[1];
            rtc_pkg::OPD_HZ:   r = r_h[2];
            rtc_pkg::OPD_QX:   r = r_q[0];
            rtc_pkg::OPD_QY:   r = r_q[1];
            rtc_pkg::OPD_QZ:   r = r_q[2];
            rtc_pkg::OPD_BEST: r = r_best_dist;
            default:           r = '0;
        endcase
        return r;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_org[k] <= '0;
                r_dir[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rtc_pkg::CFG_ORG_X: r_org[0] <= i_cfg_data;
                rtc_pkg::CFG_ORG_Y: r_org[1] <= i_cfg_data;
                rtc_pkg::CFG_ORG_Z: r_org[2] <= i_cfg_data;
                rtc_pkg::CFG_DIR_X: r_dir[0] <= i_cfg_data;
                rtc_pkg::CFG_DIR_Y: r_dir[1] <= i_cfg_data;
                rtc_pkg::CFG_DIR_Z: r_dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Edge and origin-offset vectors, formed as the request is taken.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_e1[0] <= rtc_pkg::sat_diff(i_v1_x, i_v0_x);
            r_e1[1] <= rtc_pkg::sat_diff(i_v1_y, i_v0_y);
            r_e1[2] <= rtc_pkg::sat_diff(i_v1_z, i_v0_z);
            r_e2[0] <= rtc_pkg::sat_diff(i_v2_x, i_v0_x);
            r_e2[1] <= rtc_pkg::sat_diff(i_v2_y, i_v0_y);
            r_e2[2] <= rtc_pkg::sat_diff(i_v2_z, i_v0_z);
            r_s[0]  <= rtc_pkg::sat_diff(r_org[0], i_v0_x);
            r_s[1]  <= rtc_pkg::sat_diff(r_org[1], i_v0_y);
            r_s[2]  <= rtc_pkg::sat_diff(r_org[2], i_v0_z);
            r_last  <= i_last_triangle;
        end
    end

    // Multiplier stage.
    assign opd_a = opd_val(i_cmd.mop.a);
    assign opd_b = opd_val(i_cmd.mop.b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mop1 <= '0;
        end else begin
            r_mop1 <= i_cmd.mop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= opd_a * opd_b;
    end

    // Accumulate stage: cross products keep the exact difference and floor
    // afterwards, dot products floor each product before the sum.
    always_comb begin
        prod_f = r_prod[63:16];
        n_acc  = r_acc;
        case (r_mop1.acc)
            rtc_pkg::ACC_CROSS_FIRST: n_acc = 66'(r_prod);
            rtc_pkg::ACC_CROSS_LAST:  n_acc = r_acc - 66'(r_prod);
            rtc_pkg::ACC_DOT_FIRST:   n_acc = 66'(prod_f);
            rtc_pkg::ACC_DOT_MID:     n_acc = r_acc + 66'(prod_f);
            rtc_pkg::ACC_DOT_LAST:    n_acc = r_acc + 66'(prod_f);
            default:                  n_acc = r_acc;
        endcase
        case (r_mop1.dst)
            rtc_pkg::DST_PX: org_k = r_org[0];
            rtc_pkg::DST_PY: org_k = r_org[1];
            default:         org_k = r_org[2];
        endcase
        case (r_mop1.acc)
            rtc_pkg::ACC_CROSS_LAST: res = rtc_pkg::sat66(n_acc >>> 16);
            rtc_pkg::ACC_POINT:      res = rtc_pkg::sat66(66'(org_k) + 66'(prod_f));
            default:                 res = rtc_pkg::sat66(n_acc);
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        case (r_mop1.dst)
            rtc_pkg::DST_HX: r_h[0] <= res;
            rtc_pkg::DST_HY: r_h[1] <= res;
            rtc_pkg::DST_HZ: r_h[2] <= res;
            rtc_pkg::DST_QX: r_q[0] <= res;
            rtc_pkg::DST_QY: r_q[1] <= res;
            rtc_pkg::DST_QZ: r_q[2] <= res;
            rtc_pkg::DST_A:  r_a    <= res;
            rtc_pkg::DST_NU: r_nu   <= res;
            rtc_pkg::DST_NV: r_nv   <= res;
            rtc_pkg::DST_NT: r_nt   <= res;
            rtc_pkg::DST_PX: r_p[0] <= res;
            rtc_pkg::DST_PY: r_p[1] <= res;
            rtc_pkg::DST_PZ: r_p[2] <= res;
            default: ;
        endcase
    end

    // Division of each numerator by the determinant.
    always_comb begin
        case (i_cmd.div_sel)
            rtc_pkg::DIV_U: div_num = r_nu;
            rtc_pkg::DIV_V: div_num = r_nv;
            default:        div_num = r_nt;
        endcase
    end

    rtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_a),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dsel <= i_cmd.div_sel;
        end
        if (div_done) begin
            case (r_dsel)
                rtc_pkg::DIV_U: r_u <= div_quo;
                rtc_pkg::DIV_V: r_v <= div_quo;
                default:        r_t <= div_quo;
            endcase
        end
    end

    assign uv_sum = 33'(r_u) + 33'(r_v);
    assign t_ok   = (r_t > 32'sd1);
    assign better = t_ok && (!r_any || (r_t < r_best_dist));

    // Nearest-hit record and triangle count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_out) begin
            r_best_dist <= rtc_pkg::QMax;
            r_best_u    <= '0;
            r_best_v    <= '0;
            r_best_idx  <= '0;
            r_any       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.upd && better) begin
                r_best_dist <= r_t;
                r_best_u    <= r_u;
                r_best_v    <= r_v;
                r_best_idx  <= r_cnt;
            end
            if (i_cmd.upd && t_ok) begin
                r_any <= 1'b1;
            end
            if (i_cmd.count) begin
                r_cnt <= (r_cnt == CntLast) ? 16'd0 : r_cnt + 16'd1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_hit  <= r_any;
            r_o_dist <= r_any ? r_best_dist : '0;
            r_o_u    <= r_any ? r_best_u : '0;
            r_o_v    <= r_any ? r_best_v : '0;
            r_o_idx  <= r_any ? r_best_idx : '0;
            r_o_px   <= r_any ? r_p[0] : '0;
            r_o_py   <= r_any ? r_p[1] : '0;
            r_o_pz   <= r_any ? r_p[2] : '0;
        end
    end

    always_comb begin
        o_sts.a_zero   = (r_a == '0);
        o_sts.u_ok     = !r_u[31] && (r_u <= rtc_pkg::QOne);
        o_sts.v_ok     = !r_v[31] && (uv_sum <= 33'sd65536);
        o_sts.any_hit  = r_any;
        o_sts.last     = r_last;
        o_sts.div_busy = div_busy;
        o_sts.div_done = div_done;
    end

    assign o_hit_found    = r_o_hit;
    assign o_hit_distance = r_o_dist;
    assign o_bary_u       = r_o_u;
    assign o_bary_v       = r_o_v;
    assign o_hit_index    = r_o_idx;
    assign o_point_x      = r_o_px;
    assign o_point_y      = r_o_py;
    assign o_point_z      = r_o_pz;

endmodule

// File: rtl/rtc_ctrl.sv
// ----------------------------------------------------------------------------
// rtc_ctrl
// Sequencer: steps the multiply schedule, the three divisions with their early
// rejections, the nearest-hit update, the hit point and the result hand-over.
// ----------------------------------------------------------------------------
module rtc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  rtc_pkg::t_sts i_sts,
    output rtc_pkg::t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_MUL    = 14'b00000000000010,
        S_CHK_A  = 14'b00000000000100,
        S_DIV_U  = 14'b00000000001000,
        S_CHK_U  = 14'b00000000010000,
        S_DIV_V  = 14'b00000000100000,
        S_CHK_V  = 14'b00000001000000,
        S_DIV_T  = 14'b00000010000000,
        S_UPD    = 14'b00000100000000,
        S_FINISH = 14'b00001000000000,
        S_PT     = 14'b00010000000000,
        S_PDRAIN = 14'b00100000000000,
        S_OUT    = 14'b01000000000000,
        S_SPARE  = 14'b10000000000000
    } t_state;

    t_state        r_state, n_state;
    logic [4:0]    r_step, n_step;
    logic          r_out_valid, n_out_valid;
    rtc_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_step      = '0;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mop = rtc_pkg::mop_of(r_step);
                n_step  = r_step + 5'd1;
                if (r_step == rtc_pkg::MopLast) begin
                    n_state = S_CHK_A;
                end
            end
            S_CHK_A: begin
                if (i_sts.a_zero) begin
                    n_state = S_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rtc_pkg::DIV_U;
                    n_state       = S_DIV_U;
                end
            end
            S_DIV_U: begin
                if (i_sts.div_done) begin
                    n_state = S_CHK_U;
                end
            end
            S_CHK_U: begin
                if (i_sts.u_ok) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rtc_pkg::DIV_V;
                    n_state       = S_DIV_V;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV_V: begin
                if (i_sts.div_done) begin
                    n_state = S_CHK_V;
                end
            end
            S_CHK_V: begin
                if (i_sts.v_ok) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rtc_pkg::DIV_T;
                    n_state       = S_DIV_T;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV_T: begin
                if (i_sts.div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                cmd.upd = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                cmd.count = 1'b1;
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (i_sts.any_hit) begin
                    n_step  = rtc_pkg::PtFirst;
                    n_state = S_PT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PT: begin
                cmd.mop = rtc_pkg::mop_of(r_step);
                n_step  = r_step + 5'd1;
                if (r_step == rtc_pkg::PtLast) begin
                    n_state = S_PDRAIN;
                end
            end
            S_PDRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |-> !i_sts.div_busy)
        else $error("divider started while busy");

    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MUL))
        else $error("accepted request did not start the multiply schedule");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DIV_U || r_state == S_DIV_V ||
                            r_state == S_DIV_T))
        else $error("divider finished outside a wait state");

    a_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> !i_sts.any_hit)
        else $error("hit record not cleared after result");

endmodule
